/* hdl/iscd_pkg.sv */
// Package for the input set change detector.
// Holds the operation codes, the queued command type and the back-end state type.
// No dependencies.
package iscd_pkg;

  // Widths of the id, operation and slot fields on the ports.
  localparam int IN_ID_W     = 16;
  localparam int OUT_ID_W    = 16;
  localparam int OP_W        = 3;
  localparam int SLOT_W      = 3;

  // At most this many results come out of one list operation.
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // Depth of the command queue between the front and the back end.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Operation codes as they arrive on the input channel.
  localparam logic [OP_W-1:0] OP_WRITE       = 3'd0;
  localparam logic [OP_W-1:0] OP_FILL_CUR    = 3'd1;
  localparam logic [OP_W-1:0] OP_FILL_OLD    = 3'd2;
  localparam logic [OP_W-1:0] OP_SWAP        = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY       = 3'd4;
  localparam logic [OP_W-1:0] OP_LIST_ACT    = 3'd5;
  localparam logic [OP_W-1:0] OP_LIST_INACT  = 3'd6;

  // Classified command handed from the front end to the back end.
  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_FILL_CUR,
    CMD_FILL_OLD,
    CMD_SWAP,
    CMD_QUERY,
    CMD_LIST_ACT,
    CMD_LIST_INACT
  } cmd_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [SLOT_W-1:0]   slot;
    logic [IN_ID_W-1:0]  id;
  } item_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } bst_t;

endpackage

/* hdl/input_set_change_detector.sv */
// Input set change detector: two banks of active input ids diffed per report.
// An accepted beat is queued and taken from the queue head by the back end while it is idle;
// a query result is registered in the output register, and a list's results come out through
// the pending register, since each found id waits for the next. Writes, fills, swaps and
// queries are run in the idle state; a list walks the slots, then flushes. A two-entry queue
// lets the input side run ahead. Synchronous active-low reset clears both banks, bank zero current.
module input_set_change_detector import iscd_pkg::*; #(
  parameter int SLOTS    = 8,
  parameter int ID_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [OP_W-1:0]             in_op,
  input  logic [SLOT_W-1:0]           in_slot,
  input  logic signed [IN_ID_W-1:0]   in_id,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [OUT_ID_W-1:0]  out_id_out,
  output logic                        out_went_active,
  output logic                        out_is_query,
  output logic                        out_now_active,
  output logic                        out_now_inactive,
  output logic                        out_last
);

  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;
  item_t push_item;
  item_t head_item;

  // Classify incoming beats.
  iscd_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_op    (in_op),
    .in_slot  (in_slot),
    .in_id    (in_id),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  // Command queue.
  iscd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Banks, sequencer and result register.
  iscd_back #(
    .SLOTS    (SLOTS),
    .ID_WIDTH (ID_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_item           (head_item),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_id_out       (out_id_out),
    .out_went_active  (out_went_active),
    .out_is_query     (out_is_query),
    .out_now_active   (out_now_active),
    .out_now_inactive (out_now_inactive),
    .out_last         (out_last)
  );

endmodule

/* hdl/iscd_front.sv */
// Front end of the input set change detector.
// Accepts input beats, classifies the operation and drops beats that do nothing.
// Depends on iscd_pkg.
module iscd_front import iscd_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [OP_W-1:0]            in_op,
  input  logic [SLOT_W-1:0]          in_slot,
  input  logic signed [IN_ID_W-1:0]  in_id,
  input  logic                       q_full,
  output logic                       q_push,
  output item_t                      q_item
);

  logic keep;
  logic slot_ok;

  // A write beyond the last slot is ignored.
  assign slot_ok = 32'(in_slot) < 32'(SLOTS);

  // Classify the beat into a queued command.
  always_comb begin
    keep        = 1'b1;
    q_item.slot = in_slot;
    q_item.id   = in_id;
    q_item.cmd  = CMD_SWAP;
    case (in_op)
      OP_WRITE: begin
        q_item.cmd = CMD_WRITE;
        keep       = slot_ok;
      end
      OP_FILL_CUR:   q_item.cmd = CMD_FILL_CUR;
      OP_FILL_OLD:   q_item.cmd = CMD_FILL_OLD;
      OP_SWAP:       q_item.cmd = CMD_SWAP;
      OP_QUERY:      q_item.cmd = CMD_QUERY;
      OP_LIST_ACT:   q_item.cmd = CMD_LIST_ACT;
      OP_LIST_INACT: q_item.cmd = CMD_LIST_INACT;
      default:       keep = 1'b0;
    endcase
  end

  // Stall only while the queue has no room.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && keep;

endmodule

/* hdl/iscd_queue.sv */
// Short command queue between the front and the back end.
// Holds QUEUE_DEPTH classified commands in arrival order.
// Depends on iscd_pkg.
module iscd_queue import iscd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head_item,
  output logic  full,
  output logic  empty
);

  item_t             entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full      = count_r == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign empty     = count_r == '0;
  assign head_item = entry_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* hdl/iscd_back.sv */
// Back end of the input set change detector.
// Holds both id banks, runs queued commands and drives the registered result beat.
// Depends on iscd_pkg.
module iscd_back import iscd_pkg::*; #(
  parameter int SLOTS    = 8,
  parameter int ID_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  item_t                       q_item,
  input  logic                        q_empty,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [OUT_ID_W-1:0]  out_id_out,
  output logic                        out_went_active,
  output logic                        out_is_query,
  output logic                        out_now_active,
  output logic                        out_now_inactive,
  output logic                        out_last
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Banks and bank selection.
  logic [ID_WIDTH-1:0] bank0_r [SLOTS];
  logic [ID_WIDTH-1:0] bank1_r [SLOTS];
  logic                sel_r;
  logic [ID_WIDTH-1:0] cur_bank [SLOTS];
  logic [ID_WIDTH-1:0] old_bank [SLOTS];

  // Sequencer state.
  bst_t                state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic                walk_act_r, walk_act_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic [ID_WIDTH-1:0] pend_id_r, pend_id_nxt;

  // Output register.
  logic                out_valid_r;
  logic [OUT_ID_W-1:0] id_out_r, id_out_nxt;
  logic                went_active_r, went_active_nxt;
  logic                is_query_r, is_query_nxt;
  logic                now_active_r, now_active_nxt;
  logic                now_inactive_r, now_inactive_nxt;
  logic                last_r, last_nxt;
  logic                load_out;
  logic                out_free;

  // Bank update strobes.
  logic wr_en, fill_cur_en, fill_old_en, swap_en;
  logic b0_fill, b1_fill, b0_wr, b1_wr;

  // Id conversions.
  logic [31:0]         qid_ext;
  logic [ID_WIDTH-1:0] qid;
  logic [31:0]         qid_zext;
  logic [31:0]         pend_zext;

  // Compare results.
  logic [ID_WIDTH-1:0] walk_id;
  logic                in_cur, in_old, other_has;
  logic                hit, walk_done;

  assign out_free = !out_valid_r || !out_stall;

  // Select current and last bank by the bank select bit.
  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      cur_bank[j] = sel_r ? bank1_r[j] : bank0_r[j];
      old_bank[j] = sel_r ? bank0_r[j] : bank1_r[j];
    end
  end

  // Ids are sign-extended and kept in ID_WIDTH bits; results show 16 bits of that.
  assign qid_ext   = 32'(signed'(q_item.id));
  assign qid       = qid_ext[ID_WIDTH-1:0];
  assign qid_zext  = 32'(qid);
  assign pend_zext = 32'(pend_id_r);

  // Query compares against every slot of both banks in parallel.
  always_comb begin
    in_cur = 1'b0;
    in_old = 1'b0;
    for (int j = 0; j < SLOTS; j++) begin
      in_cur = in_cur | (cur_bank[j] == qid);
      in_old = in_old | (old_bank[j] == qid);
    end
  end

  // The walk checks one slot a cycle against the other bank, held on a stalled hit.
  assign walk_id   = walk_act_r ? cur_bank[idx_r] : old_bank[idx_r];
  always_comb begin
    other_has = 1'b0;
    for (int j = 0; j < SLOTS; j++) begin
      other_has = other_has | ((walk_act_r ? old_bank[j] : cur_bank[j]) == walk_id);
    end
  end
  assign hit       = !other_has;
  assign walk_done = idx_r == IDX_W'(SLOTS - 1);

  // Sequencer next state and result selection.
  always_comb begin
    state_nxt        = state_r;
    idx_nxt          = idx_r;
    n_nxt            = n_r;
    walk_act_nxt     = walk_act_r;
    pend_valid_nxt   = pend_valid_r;
    pend_id_nxt      = pend_id_r;
    q_pop            = 1'b0;
    load_out         = 1'b0;
    wr_en            = 1'b0;
    fill_cur_en      = 1'b0;
    fill_old_en      = 1'b0;
    swap_en          = 1'b0;
    id_out_nxt       = pend_zext[OUT_ID_W-1:0];
    went_active_nxt  = walk_act_r;
    is_query_nxt     = 1'b0;
    now_active_nxt   = 1'b0;
    now_inactive_nxt = 1'b0;
    last_nxt         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          case (q_item.cmd)
            CMD_WRITE: begin
              wr_en = 1'b1;
              q_pop = 1'b1;
            end
            CMD_FILL_CUR: begin
              fill_cur_en = 1'b1;
              q_pop       = 1'b1;
            end
            CMD_FILL_OLD: begin
              fill_old_en = 1'b1;
              q_pop       = 1'b1;
            end
            CMD_SWAP: begin
              swap_en = 1'b1;
              q_pop   = 1'b1;
            end
            CMD_QUERY: begin
              if (out_free) begin
                q_pop            = 1'b1;
                load_out         = 1'b1;
                id_out_nxt       = qid_zext[OUT_ID_W-1:0];
                went_active_nxt  = 1'b0;
                is_query_nxt     = 1'b1;
                now_active_nxt   = in_cur && !in_old;
                now_inactive_nxt = !in_cur && in_old;
                last_nxt         = 1'b1;
              end
            end
            CMD_LIST_ACT, CMD_LIST_INACT: begin
              q_pop          = 1'b1;
              walk_act_nxt   = q_item.cmd == CMD_LIST_ACT;
              idx_nxt        = '0;
              n_nxt          = '0;
              pend_valid_nxt = 1'b0;
              state_nxt      = ST_WALK;
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      ST_WALK: begin
        // A found id waits in the pending register until the next one shows
        // whether it is the final result.
        if (hit) begin
          if (!pend_valid_r || out_free) begin
            load_out       = pend_valid_r;
            pend_valid_nxt = 1'b1;
            pend_id_nxt    = walk_id;
            n_nxt          = n_r + 1'b1;
            if (walk_done || n_r == CNT_W'(MAX_RESULTS - 1)) begin
              state_nxt = ST_FLUSH;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
        end else if (walk_done) begin
          state_nxt = ST_FLUSH;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_FLUSH: begin
        // The pending id, if any, is the final result of the list.
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          load_out       = 1'b1;
          last_nxt       = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Map current/last bank strobes onto the physical banks.
  assign b0_fill = (fill_cur_en && !sel_r) || (fill_old_en && sel_r);
  assign b1_fill = (fill_cur_en && sel_r) || (fill_old_en && !sel_r);
  assign b0_wr   = wr_en && !sel_r;
  assign b1_wr   = wr_en && sel_r;

  // Bank storage and bank select.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
      for (int j = 0; j < SLOTS; j++) begin
        bank0_r[j] <= '0;
        bank1_r[j] <= '0;
      end
    end else begin
      if (swap_en) begin
        sel_r <= ~sel_r;
      end
      for (int j = 0; j < SLOTS; j++) begin
        if (b0_fill || (b0_wr && 32'(q_item.slot) == j)) begin
          bank0_r[j] <= qid;
        end
        if (b1_fill || (b1_wr && 32'(q_item.slot) == j)) begin
          bank1_r[j] <= qid;
        end
      end
    end
  end

  // Sequencer control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      n_r          <= '0;
      walk_act_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      n_r          <= n_nxt;
      walk_act_r   <= walk_act_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pend_id_r <= pend_id_nxt;
    if (load_out) begin
      id_out_r       <= id_out_nxt;
      went_active_r  <= went_active_nxt;
      is_query_r     <= is_query_nxt;
      now_active_r   <= now_active_nxt;
      now_inactive_r <= now_inactive_nxt;
      last_r         <= last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_id_out       = signed'(id_out_r);
  assign out_went_active  = went_active_r;
  assign out_is_query     = is_query_r;
  assign out_now_active   = now_active_r;
  assign out_now_inactive = now_inactive_r;
  assign out_last         = last_r;

endmodule
